>>> rtl/core/prr_pkg.sv
// Shared types and codes for the pipelined response reorder block.
package prr_pkg;

  localparam int FIELD_BITS = 16;

  typedef enum logic [1:0] {
    CMD_OPEN   = 2'd0,
    CMD_REQ    = 2'd1,
    CMD_COMMIT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NUMBERED = 3'd0,
    KIND_REFUSED  = 3'd1,
    KIND_SENT     = 3'd2,
    KIND_DROPPED  = 3'd3,
    KIND_OPENED   = 3'd4
  } kind_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic                  is_last;
    logic [FIELD_BITS-1:0] seq;
    logic [FIELD_BITS-1:0] payload;
  } cmd_item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] seq;
    logic [FIELD_BITS-1:0] payload;
    logic                  close_now;
    logic                  last;
  } result_t;

endpackage

>>> rtl/core/pipelined_response_reorder.sv
// Top level of the pipelined response reorder block.
// An item passes the command queue and result queue registers to the outputs.
// Throughput: one item per cycle while the result queue has room and no drain runs;
// a commit releasing k held responses drains one per cycle while the queue has room.
// Reset: synchronous, active low; clears counters, close state, held valid bits
// and both queues; the window store contents are not cleared.
module pipelined_response_reorder #(
  parameter int WINDOW       = 16,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic        in_is_last_request,
  input  logic [15:0] in_resp_seq,
  input  logic [15:0] in_payload_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [15:0] out_seq_out,
  output logic [15:0] out_payload_out,
  output logic        out_close_now,
  output logic        out_last
);
  import prr_pkg::*;

  cmd_item_t                  cq_item;
  logic                       cq_empty;
  logic                       cq_pop;
  result_t                    rq_item;
  logic                       rq_push;
  logic                       rq_full;
  logic [$bits(result_t)-1:0] rq_rdata;
  result_t                    res;

  prr_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_cmd             (in_cmd),
    .in_is_last_request (in_is_last_request),
    .in_resp_seq        (in_resp_seq),
    .in_payload_in      (in_payload_in),
    .cq_pop             (cq_pop),
    .cq_item            (cq_item),
    .cq_empty           (cq_empty)
  );

  prr_back #(
    .WINDOW       (WINDOW),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_item  (cq_item),
    .cq_pop   (cq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_item  (rq_item)
  );

  prr_fifo #(
    .WIDTH($bits(result_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_item),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign res             = result_t'(rq_rdata);
  assign out_kind        = res.kind;
  assign out_seq_out     = res.seq;
  assign out_payload_out = res.payload;
  assign out_close_now   = res.close_now;
  assign out_last        = res.last;

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full)
    else $error("result pushed into a full queue");

  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty)
    else $error("command popped from an empty queue");

  a_close_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (rq_push && rq_item.close_now) |-> (rq_item.kind == KIND_SENT && rq_item.last))
    else $error("close flag on a result that is not a final send");

  a_no_push_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (rq_push && rq_item.close_now) |=> !(rq_push && rq_item.kind == KIND_SENT))
    else $error("send right after the connection closed");
`endif

endmodule

>>> rtl/core/prr_fifo.sv
// Two-entry register queue with full and empty flags.
module prr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/prr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/core/prr_front.sv
// Front end: accepts items, drops unused commands and queues the rest.
module prr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_cmd,
  input  logic                in_is_last_request,
  input  logic [15:0]         in_resp_seq,
  input  logic [15:0]         in_payload_in,
  input  logic                cq_pop,
  output prr_pkg::cmd_item_t  cq_item,
  output logic                cq_empty
);
  import prr_pkg::*;

  cmd_item_t                  item;
  logic                       known;
  logic                       q_push;
  logic [$bits(cmd_item_t)-1:0] q_rdata;

  always_comb begin
    item         = '0;
    item.cmd     = cmd_t'(in_cmd);
    item.is_last = in_is_last_request;
    item.seq     = in_resp_seq;
    item.payload = in_payload_in;
    case (in_cmd)
      CMD_OPEN, CMD_REQ, CMD_COMMIT: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // drop unused commands at the door
  assign q_push  = in_push && !in_full && known;
  assign cq_item = cmd_item_t'(q_rdata);

  prr_fifo #(
    .WIDTH($bits(cmd_item_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (item),
    .full  (in_full),
    .pop   (cq_pop),
    .rdata (q_rdata),
    .empty (cq_empty)
  );

endmodule

>>> rtl/core/prr_back.sv
// Back end: sequence state, window store and in-order release of responses.
module prr_back #(
  parameter int WINDOW       = 16,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cq_empty,
  input  prr_pkg::cmd_item_t cq_item,
  output logic               cq_pop,
  input  logic               rq_full,
  output logic               rq_push,
  output prr_pkg::result_t   rq_item
);
  import prr_pkg::*;

  localparam int IDX_BITS = $clog2(WINDOW);
  localparam logic [SEQ_BITS:0]   WIN_S     = (SEQ_BITS+1)'(WINDOW);
  localparam logic [IDX_BITS:0]   WIN_I     = (IDX_BITS+1)'(WINDOW);
  localparam logic [IDX_BITS-1:0] HEAD_LAST = IDX_BITS'(WINDOW - 1);
  localparam logic [SEQ_BITS-1:0] SEQ_ONE   = SEQ_BITS'(1);
  localparam logic [IDX_BITS-1:0] IDX_ONE   = IDX_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SEQ_BITS-1:0]     next_req_r, next_req_nxt;
  logic [SEQ_BITS-1:0]     next_send_r, next_send_nxt;
  logic [SEQ_BITS-1:0]     close_seq_r, close_seq_nxt;
  logic                    close_marked_r, close_marked_nxt;
  logic                    closed_r, closed_nxt;
  logic [IDX_BITS-1:0]     head_r, head_nxt;
  logic [WINDOW-1:0]       valid_r, valid_nxt;

  logic [SEQ_BITS+15:0]     seq_ext;
  logic [SEQ_BITS-1:0]      seq_w;
  logic [PAYLOAD_BITS+15:0] pay_ext;
  logic [PAYLOAD_BITS-1:0]  pay_w;
  logic [SEQ_BITS-1:0]      diff;
  logic                     in_win;
  logic [IDX_BITS:0]        slot_sum;
  logic [IDX_BITS:0]        slot_wrap;
  logic [IDX_BITS-1:0]      slot;
  logic [IDX_BITS-1:0]      head_inc;
  logic                     closing;
  logic                     go;
  logic [SEQ_BITS+15:0]     send_seq_ext;
  logic [SEQ_BITS+15:0]     req_seq_ext;
  logic [PAYLOAD_BITS+15:0] pay_out_ext;
  logic [PAYLOAD_BITS+15:0] ram_out_ext;

  logic                     ram_we;
  logic                     ram_re;
  logic [PAYLOAD_BITS-1:0]  ram_rdata;

  assign seq_ext      = {{SEQ_BITS{1'b0}}, cq_item.seq};
  assign seq_w        = seq_ext[SEQ_BITS-1:0];
  assign pay_ext      = {{PAYLOAD_BITS{1'b0}}, cq_item.payload};
  assign pay_w        = pay_ext[PAYLOAD_BITS-1:0];
  assign diff         = seq_w - next_send_r;
  assign in_win       = ({1'b0, diff} < WIN_S);
  assign slot_sum     = {1'b0, head_r} + {1'b0, diff[IDX_BITS-1:0]};
  assign slot_wrap    = (slot_sum >= WIN_I) ? (slot_sum - WIN_I) : slot_sum;
  assign slot         = slot_wrap[IDX_BITS-1:0];
  assign head_inc     = (head_r == HEAD_LAST) ? '0 : head_r + IDX_ONE;
  assign closing      = close_marked_r && (next_send_r == close_seq_r);
  assign go           = (state_r == ST_IDLE) && !cq_empty && !rq_full;
  assign cq_pop       = go;
  assign send_seq_ext = {16'b0, next_send_r};
  assign req_seq_ext  = {16'b0, next_req_r};
  assign pay_out_ext  = {16'b0, pay_w};
  assign ram_out_ext  = {16'b0, ram_rdata};

  always_comb begin
    state_nxt        = state_r;
    next_req_nxt     = next_req_r;
    next_send_nxt    = next_send_r;
    close_seq_nxt    = close_seq_r;
    close_marked_nxt = close_marked_r;
    closed_nxt       = closed_r;
    head_nxt         = head_r;
    valid_nxt        = valid_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    rq_push          = 1'b0;
    rq_item          = '0;

    case (state_r)
      ST_IDLE: begin
        if (go) begin
          case (cq_item.cmd)
            CMD_OPEN: begin
              next_req_nxt     = '0;
              next_send_nxt    = '0;
              close_seq_nxt    = '0;
              close_marked_nxt = 1'b0;
              closed_nxt       = 1'b0;
              head_nxt         = '0;
              valid_nxt        = '0;
              rq_push          = 1'b1;
              rq_item.kind     = KIND_OPENED;
              rq_item.last     = 1'b1;
            end
            CMD_REQ: begin
              rq_push      = 1'b1;
              rq_item.last = 1'b1;
              if (close_marked_r) begin
                rq_item.kind = KIND_REFUSED;
              end else begin
                rq_item.kind = KIND_NUMBERED;
                rq_item.seq  = req_seq_ext[15:0];
                if (cq_item.is_last) begin
                  close_marked_nxt = 1'b1;
                  close_seq_nxt    = next_req_r;
                end
                next_req_nxt = next_req_r + SEQ_ONE;
              end
            end
            CMD_COMMIT: begin
              if (closed_r || !in_win) begin
                rq_push      = 1'b1;
                rq_item.kind = KIND_DROPPED;
                rq_item.last = 1'b1;
              end else if (diff != '0) begin
                // hold out-of-order response in its window slot
                ram_we          = 1'b1;
                valid_nxt[slot] = 1'b1;
              end else begin
                rq_push           = 1'b1;
                rq_item.kind      = KIND_SENT;
                rq_item.seq       = send_seq_ext[15:0];
                rq_item.payload   = pay_out_ext[15:0];
                rq_item.close_now = closing;
                if (closing) begin
                  closed_nxt   = 1'b1;
                  rq_item.last = 1'b1;
                end else begin
                  next_send_nxt = next_send_r + SEQ_ONE;
                  head_nxt      = head_inc;
                  if (valid_r[head_inc]) begin
                    ram_re    = 1'b1;
                    state_nxt = ST_DRAIN;
                  end else begin
                    rq_item.last = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (!rq_full) begin
          rq_push           = 1'b1;
          rq_item.kind      = KIND_SENT;
          rq_item.seq       = send_seq_ext[15:0];
          rq_item.payload   = ram_out_ext[15:0];
          rq_item.close_now = closing;
          valid_nxt[head_r] = 1'b0;
          if (closing) begin
            closed_nxt   = 1'b1;
            rq_item.last = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            next_send_nxt = next_send_r + SEQ_ONE;
            head_nxt      = head_inc;
            if (valid_r[head_inc]) begin
              ram_re = 1'b1;
            end else begin
              rq_item.last = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      next_req_r     <= '0;
      next_send_r    <= '0;
      close_seq_r    <= '0;
      close_marked_r <= 1'b0;
      closed_r       <= 1'b0;
      head_r         <= '0;
      valid_r        <= '0;
    end else begin
      state_r        <= state_nxt;
      next_req_r     <= next_req_nxt;
      next_send_r    <= next_send_nxt;
      close_seq_r    <= close_seq_nxt;
      close_marked_r <= close_marked_nxt;
      closed_r       <= closed_nxt;
      head_r         <= head_nxt;
      valid_r        <= valid_nxt;
    end
  end

  prr_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (pay_w),
    .re    (ram_re),
    .raddr (head_inc),
    .rdata (ram_rdata)
  );

endmodule

>>> sim/tb_top.sv
// Testbench for pipelined_response_reorder: directed and random item streams.
module tb_top;
  import prr_pkg::*;

  localparam int WIN = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_cmd = 2'd0;
  logic        in_is_last_request = 1'b0;
  logic [15:0] in_resp_seq = 16'd0;
  logic [15:0] in_payload_in = 16'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_seq_out;
  logic [15:0] out_payload_out;
  logic        out_close_now;
  logic        out_last;

  pipelined_response_reorder u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_cmd             (in_cmd),
    .in_is_last_request (in_is_last_request),
    .in_resp_seq        (in_resp_seq),
    .in_payload_in      (in_payload_in),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_seq_out        (out_seq_out),
    .out_payload_out    (out_payload_out),
    .out_close_now      (out_close_now),
    .out_last           (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Connection state mirrored from the item stream
  logic [15:0] nxt_req;
  logic [15:0] nxt_send;
  logic [15:0] close_num;
  logic        close_marked;
  logic        conn_closed;
  logic        held_vld [WIN];
  logic [15:0] held_pay [WIN];
  int          head;

  result_t     batch [$];
  result_t     pending_results [$];

  int n_errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_full_drain = 0;
  int n_closes = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int rx_stall = 0;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    n_errors++;
    if (n_errors <= 20) begin
      $display("mismatch: %s got %0h expected %0h at result %0d", what, got, want, n_checked);
    end
  endtask

  function automatic void clear_connection();
    nxt_req = '0;
    nxt_send = '0;
    close_num = '0;
    close_marked = 1'b0;
    conn_closed = 1'b0;
    head = 0;
    for (int i = 0; i < WIN; i++) begin
      held_vld[i] = 1'b0;
    end
  endfunction

  function automatic void add_result(kind_t k, logic [15:0] s, logic [15:0] p, logic c);
    result_t r;
    r.kind = k;
    r.seq = s;
    r.payload = p;
    r.close_now = c;
    r.last = 1'b0;
    batch.insert(batch.size(), r);
  endfunction

  function automatic bit release_one(logic [15:0] seq, logic [15:0] pay);
    bit closing;
    closing = close_marked && (seq == close_num);
    add_result(KIND_SENT, seq, pay, closing);
    if (closing) begin
      conn_closed = 1'b1;
      n_closes++;
    end else begin
      nxt_send = nxt_send + 16'd1;
      head = (head + 1) % WIN;
    end
    return closing;
  endfunction

  function automatic void predict_item(logic [1:0] cmd, logic is_last, logic [15:0] seq,
                                       logic [15:0] pay);
    logic [15:0] d;
    logic [15:0] hp;
    int          slot;
    int          i;
    bit          done;
    batch.delete();
    case (cmd)
      CMD_OPEN: begin
        clear_connection();
        add_result(KIND_OPENED, '0, '0, 1'b0);
      end
      CMD_REQ: begin
        if (close_marked) begin
          add_result(KIND_REFUSED, '0, '0, 1'b0);
        end else begin
          if (is_last) begin
            close_marked = 1'b1;
            close_num = nxt_req;
          end
          add_result(KIND_NUMBERED, nxt_req, '0, 1'b0);
          nxt_req = nxt_req + 16'd1;
        end
      end
      CMD_COMMIT: begin
        d = seq - nxt_send;
        if (conn_closed || d >= WIN) begin
          add_result(KIND_DROPPED, '0, '0, 1'b0);
        end else if (d != 0) begin
          slot = (head + int'(d)) % WIN;
          held_vld[slot] = 1'b1;
          held_pay[slot] = pay;
        end else begin
          done = release_one(seq, pay);
          i = 0;
          while (!done && i < WIN - 1 && held_vld[head]) begin
            hp = held_pay[head];
            held_vld[head] = 1'b0;
            done = release_one(nxt_send, hp);
            i++;
          end
        end
      end
      default: begin
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
      if (batch.size() == WIN) begin
        n_full_drain++;
      end
      foreach (batch[k]) begin
        pending_results.insert(pending_results.size(), batch[k]);
      end
    end
  endfunction

  // Called just after a rising edge; returns after the accepting edge, plus any random idle gap
  task automatic send_item(logic [1:0] cmd, logic is_last, logic [15:0] seq, logic [15:0] pay);
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_is_last_request <= is_last;
    in_resp_seq <= seq;
    in_payload_in <= pay;
    do begin
      @(posedge clk);
    end while (in_full);
    predict_item(cmd, is_last, seq, pay);
    n_items++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", out_kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_seq_out !== want.seq) report_mismatch("seq_out", out_seq_out, want.seq);
        if (out_payload_out !== want.payload) begin
          report_mismatch("payload_out", out_payload_out, want.payload);
        end
        if (out_close_now !== want.close_now) begin
          report_mismatch("close_now", out_close_now, want.close_now);
        end
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
      n_checked++;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_pop <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(1, 18) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic wait_for_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      send_item(CMD_OPEN, 1'($urandom), 16'($urandom), 16'($urandom));
    end else if (r <= 2) begin
      send_item(CMD_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom));
    end else if (r <= 4) begin
      send_item(CMD_REQ, 1'($urandom_range(0, 3) == 0), 16'($urandom), 16'($urandom));
    end else if (r <= 6) begin
      send_item(CMD_COMMIT, 1'($urandom), 16'($urandom), 16'($urandom));
    end else if (r == 7) begin
      send_item(CMD_COMMIT, 1'($urandom), nxt_send - 16'($urandom_range(1, 4)),
                16'($urandom));
    end else begin
      send_item(CMD_COMMIT, 1'($urandom), nxt_send + 16'($urandom_range(0, 40)),
                16'($urandom));
    end
  endtask

  // Usually an open, a run of requests, then commits of those numbers in some order, with noise and repeated commits
  task automatic run_session();
    int          nreq;
    int          mode;
    int          j;
    int          tmp;
    int          order [$];
    logic [15:0] base;
    if ($urandom_range(0, 9) < 7) begin
      send_item(CMD_OPEN, 1'($urandom), 16'($urandom), 16'($urandom));
    end
    nreq = $urandom_range(1, WIN);
    for (int i = 0; i < nreq; i++) begin
      send_item(CMD_REQ, 1'(i == nreq - 1 && $urandom_range(0, 2) == 0), 16'($urandom),
                16'($urandom));
    end
    base = nxt_send;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < nreq; i++) begin
      order.insert(order.size(), (mode == 0) ? nreq - 1 - i : i);
    end
    if (mode == 1 || mode == 2) begin
      for (int i = nreq - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[k]) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_item(CMD_COMMIT, 1'($urandom), base + 16'(order[k]), 16'($urandom));
      if ($urandom_range(0, 15) == 0) begin
        send_item(CMD_COMMIT, 1'($urandom), base + 16'(order[k]), 16'($urandom));
      end
    end
  endtask

  task automatic test_open_and_numbering();
    send_item(CMD_OPEN, 1'b0, 16'h0000, 16'h0000);
    send_item(CMD_REQ, 1'b0, 16'hffff, 16'hffff);
    send_item(CMD_REQ, 1'b0, 16'h0000, 16'h0000);
    send_item(CMD_UNUSED, 1'b1, 16'hffff, 16'hffff);
  endtask

  task automatic test_hold_and_release();
    send_item(CMD_COMMIT, 1'b0, 16'd1, 16'hffff);
    send_item(CMD_COMMIT, 1'b1, 16'd1, 16'h1234);
    send_item(CMD_COMMIT, 1'b0, 16'd0, 16'h0000);
    send_item(CMD_COMMIT, 1'b0, 16'd17, 16'ha5a5);
    send_item(CMD_COMMIT, 1'b0, 16'd18, 16'h5a5a);
    send_item(CMD_COMMIT, 1'b0, 16'd1, 16'h0001);
    send_item(CMD_COMMIT, 1'b0, 16'hffff, 16'hffff);
  endtask

  task automatic test_close_sequence();
    send_item(CMD_REQ, 1'b1, 16'h0000, 16'h0000);
    send_item(CMD_REQ, 1'b0, 16'h0000, 16'h0000);
    send_item(CMD_COMMIT, 1'b0, 16'd2, 16'hbeef);
    send_item(CMD_COMMIT, 1'b0, 16'd3, 16'hffff);
    send_item(CMD_REQ, 1'b1, 16'h0000, 16'h0000);
    send_item(CMD_OPEN, 1'b1, 16'hffff, 16'hffff);
  endtask

  task automatic test_random_sessions(int count);
    int target;
    target = n_items + count;
    while (n_items < target) begin
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      run_session();
    end
  endtask

  task automatic test_pause_for_drain();
    wait_for_results();
    send_item(CMD_OPEN, 1'b0, 16'h0000, 16'h0000);
    send_item(CMD_REQ, 1'b0, 16'h0000, 16'h0000);
    send_item(CMD_COMMIT, 1'b0, 16'd0, 16'h00ff);
  endtask

  task automatic test_no_idle(int count);
    int target;
    target = n_items + count;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (n_items < target) begin
      run_session();
    end
    in_push <= 1'b0;
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    clear_connection();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_open_and_numbering();
    test_hold_and_release();
    test_close_sequence();
    test_random_sessions(150);
    test_pause_for_drain();
    test_random_sessions(150);
    test_no_idle(50);
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", pending_results.size(), 0);
    end
    $display("summary: %0d items sent, %0d results checked, %0d mismatches",
             n_items, n_checked, n_errors);
    $display("summary: %0d full-window drains, %0d connection closes", n_full_drain, n_closes);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
